### rtl/ibr_pkg.sv
// ----------------------------------------------------------------------------
// ibr_pkg
// Shared widths, register codes and transaction types of the int8
// batch-norm requantizer.
// ----------------------------------------------------------------------------
package ibr_pkg;

  // Default number of coefficient table entries.
  localparam int MAX_CHANNELS_DEF = 64;

  // Field widths.
  localparam int PLANE_W    = 17;
  localparam int COUNT_W    = 7;
  localparam int POS_W      = 16;
  localparam int CH_W       = 6;
  localparam int ACT_W      = 8;
  localparam int MULT_W     = 23;
  localparam int BIAS_W     = 31;
  localparam int SHIFT_W    = 5;
  localparam int PROD_W     = ACT_W + MULT_W;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Largest plane size the position counter covers.
  localparam logic [PLANE_W-1:0] PLANE_MAX = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_SIZE    = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_ACT_MIN       = 2'd2,
    CFG_ACT_MAX       = 2'd3
  } cfg_reg_t;

  // Input operation codes.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  // One coefficient table entry.
  typedef struct packed {
    logic signed [MULT_W-1:0]  mult;
    logic signed [BIAS_W-1:0]  bias;
    logic        [SHIFT_W-1:0] shift;
  } coef_t;

  // Per-sample information that travels beside the arithmetic.
  typedef struct packed {
    logic signed [ACT_W-1:0] sample;
    logic        [CH_W-1:0]  channel;
    logic                    plane_end;
  } tag_t;

  // Output clamp bounds.
  typedef struct packed {
    logic signed [ACT_W-1:0] lo;
    logic signed [ACT_W-1:0] hi;
  } bounds_t;

endpackage

### rtl/int8_batchnorm_requantizer_unit.sv
// A sample passes stage one, stages two to four and the out_valid output register.
// Throughput: one transaction per cycle; in_stall rises only when all five
// stages are full and out_stall is high.
// Reset: counters, valid bits and configuration return to their defaults.
// The coefficient RAM is not cleared; load a channel before streaming it.
// ----------------------------------------------------------------------------
// int8_batchnorm_requantizer_unit
// Per-channel int8 requantizer: x*mult + bias, rounded shift, clamp, with a
// coefficient table held in a synchronous RAM.
// ----------------------------------------------------------------------------
module int8_batchnorm_requantizer_unit
  import ibr_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration port.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic signed [ACT_W-1:0]  in_sample,
  input  logic [CH_W-1:0]          in_load_channel,
  input  logic signed [MULT_W-1:0] in_load_multiplier,
  input  logic signed [BIAS_W-1:0] in_load_bias,
  input  logic [SHIFT_W-1:0]       in_load_shift,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACT_W-1:0]  out_result,
  output logic [CH_W-1:0]          out_result_channel,
  output logic                     out_plane_end
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic          tbl_wr_en;
  logic [AW-1:0] tbl_wr_addr;
  coef_t         tbl_wr_data;
  logic          tbl_rd_en;
  logic [AW-1:0] tbl_rd_addr;
  coef_t         tbl_rd_data;
  logic          pipe_ready;
  logic          s1_valid;
  tag_t          s1_tag;
  bounds_t       bounds;

  // Front end: configuration, counters and table access.
  ibr_seq #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_sample          (in_sample),
    .in_load_channel    (in_load_channel),
    .in_load_multiplier (in_load_multiplier),
    .in_load_bias       (in_load_bias),
    .in_load_shift      (in_load_shift),
    .tbl_wr_en          (tbl_wr_en),
    .tbl_wr_addr        (tbl_wr_addr),
    .tbl_wr_data        (tbl_wr_data),
    .tbl_rd_en          (tbl_rd_en),
    .tbl_rd_addr        (tbl_rd_addr),
    .pipe_ready         (pipe_ready),
    .s1_valid           (s1_valid),
    .s1_tag             (s1_tag),
    .bounds             (bounds)
  );

  // Coefficient table.
  ibr_ram #(
    .WIDTH($bits(coef_t)),
    .DEPTH(MAX_CHANNELS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // Arithmetic pipeline and output register.
  ibr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .s1_valid           (s1_valid),
    .s1_tag             (s1_tag),
    .s1_coef            (tbl_rd_data),
    .bounds             (bounds),
    .pipe_ready         (pipe_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result         (out_result),
    .out_result_channel (out_result_channel),
    .out_plane_end      (out_plane_end)
  );

endmodule

### rtl/ibr_ram.sv
// ----------------------------------------------------------------------------
// ibr_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port and a read enable that holds the output.
// ----------------------------------------------------------------------------
module ibr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ibr_seq.sv
// ----------------------------------------------------------------------------
// ibr_seq
// Front end: configuration registers, position and channel counters, input
// handshake, coefficient table writes and reads, and the first pipeline
// stage that lines up with the table read.
// ----------------------------------------------------------------------------
module ibr_seq
  import ibr_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration port.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic signed [ACT_W-1:0]  in_sample,
  input  logic [CH_W-1:0]        in_load_channel,
  input  logic signed [MULT_W-1:0] in_load_multiplier,
  input  logic signed [BIAS_W-1:0] in_load_bias,
  input  logic [SHIFT_W-1:0]     in_load_shift,
  // Coefficient table.
  output logic                   tbl_wr_en,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] tbl_wr_addr,
  output coef_t                  tbl_wr_data,
  output logic                   tbl_rd_en,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] tbl_rd_addr,
  // Pipeline side.
  input  logic                   pipe_ready,
  output logic                   s1_valid,
  output tag_t                   s1_tag,
  output bounds_t                bounds
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [COUNT_W-1:0] CH_SAT = COUNT_W'((MAX_CHANNELS > 127) ? 127 : MAX_CHANNELS);

  logic [PLANE_W-1:0]      plane_size_r;
  logic [COUNT_W-1:0]      channel_count_r;
  logic signed [ACT_W-1:0] act_min_r;
  logic signed [ACT_W-1:0] act_max_r;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [CH_W-1:0]         ch_r, ch_nxt;
  logic                    s1_valid_r;
  tag_t                    s1_tag_r;

  logic [PLANE_W-1:0] eff_plane;
  logic [COUNT_W-1:0] eff_count;
  logic [PLANE_W-1:0] pos_inc;
  logic [COUNT_W-1:0] ch_inc;
  logic               last;
  logic               ch_wrap;
  logic [CH_W-1:0]    ch_sel;
  logic               sample_acc;
  logic               load_acc;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_size_r    <= PLANE_W'(1);
      channel_count_r <= COUNT_W'(1);
      act_min_r       <= -8'sd128;
      act_max_r       <= 8'sd127;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PLANE_SIZE:    plane_size_r    <= cfg_data[PLANE_W-1:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[COUNT_W-1:0];
        CFG_ACT_MIN:       act_min_r       <= $signed(cfg_data[ACT_W-1:0]);
        CFG_ACT_MAX:       act_max_r       <= $signed(cfg_data[ACT_W-1:0]);
        default: ;
      endcase
    end
  end

  assign bounds = '{lo: act_min_r, hi: act_max_r};

  // Input handshake: a transaction moves whenever stage one can take it.
  assign in_stall   = !pipe_ready;
  assign sample_acc = in_valid && !in_stall && (op_t'(in_operation) == OP_SAMPLE);
  assign load_acc   = in_valid && !in_stall && (op_t'(in_operation) == OP_LOAD);

  // Effective bounds and end-of-plane / channel wrap detection.
  always_comb begin
    if (plane_size_r == '0) begin
      eff_plane = PLANE_W'(1);
    end else if (plane_size_r > PLANE_MAX) begin
      eff_plane = PLANE_MAX;
    end else begin
      eff_plane = plane_size_r;
    end
    if (channel_count_r == '0) begin
      eff_count = COUNT_W'(1);
    end else if (channel_count_r > CH_SAT) begin
      eff_count = CH_SAT;
    end else begin
      eff_count = channel_count_r;
    end
    pos_inc = {1'b0, pos_r} + PLANE_W'(1);
    ch_inc  = {1'b0, ch_r} + COUNT_W'(1);
    last    = pos_inc >= eff_plane;
    ch_wrap = ch_inc >= eff_count;
    ch_sel  = (32'(ch_r) >= 32'(MAX_CHANNELS)) ? '0 : ch_r;
  end

  // Counter update on each accepted sample.
  always_comb begin
    pos_nxt = pos_r;
    ch_nxt  = ch_r;
    if (sample_acc) begin
      if (last) begin
        pos_nxt = '0;
        ch_nxt  = ch_wrap ? '0 : ch_inc[CH_W-1:0];
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ch_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // Table access. A load writes at its own edge, so a sample accepted at a
  // later edge always reads the new entry.
  assign tbl_wr_en   = load_acc && (32'(in_load_channel) < 32'(MAX_CHANNELS));
  assign tbl_wr_addr = AW'(in_load_channel);
  assign tbl_wr_data = '{mult: in_load_multiplier, bias: in_load_bias, shift: in_load_shift};
  assign tbl_rd_en   = pipe_ready;
  assign tbl_rd_addr = AW'(ch_sel);

  // Stage one: sample information beside the table read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_ready) begin
      s1_valid_r <= sample_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready) begin
      s1_tag_r <= '{sample: in_sample, channel: ch_sel, plane_end: last};
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_tag   = s1_tag_r;

  // A load transaction never enters the arithmetic pipeline.
  a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !s1_valid_r)
    else $error("load transaction produced a pipeline item");

  // The sample that ends a plane restarts the position count.
  a_plane_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_acc && last) |=> (pos_r == '0))
    else $error("position count not restarted after plane end");

  // The channel on a tag always addresses an existing table entry.
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> (32'(s1_tag_r.channel) < 32'(MAX_CHANNELS)))
    else $error("channel beyond table depth");

endmodule

### rtl/ibr_dp.sv
// ----------------------------------------------------------------------------
// ibr_dp
// Arithmetic pipeline: multiply, bias add, rounding shift, sign restore and
// clamp, with per-stage valid bits and an output register.
// ----------------------------------------------------------------------------
module ibr_dp
  import ibr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Stage one from the front end and the table.
  input  logic                    s1_valid,
  input  tag_t                    s1_tag,
  input  coef_t                   s1_coef,
  input  bounds_t                 bounds,
  output logic                    pipe_ready,
  // Result channel.
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACT_W-1:0] out_result,
  output logic [CH_W-1:0]         out_result_channel,
  output logic                    out_plane_end
);

  logic v2_r, v3_r, v4_r, v5_r;
  logic en2, en3, en4, en5;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [BIAS_W-1:0] bias2_r;
  logic [SHIFT_W-1:0]       sh2_r, sh3_r;
  tag_t                     tag2_r, tag3_r, tag4_r, tag5_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]         q_r;
  logic                     neg_r;
  logic signed [ACT_W-1:0]  res_r;

  logic signed [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-1:0]         mag;
  logic [ACC_W:0]           rnd;
  logic [ACC_W:0]           sum;
  logic [ACC_W:0]           quo;
  logic signed [ACC_W:0]    val;
  logic signed [ACC_W:0]    lo_ext, hi_ext, low_clamped, clamped;

  // A stage moves when its successor is empty or moving.
  assign en5        = !v5_r || !out_stall;
  assign en4        = !v4_r || en5;
  assign en3        = !v3_r || en4;
  assign en2        = !v2_r || en3;
  assign pipe_ready = !s1_valid || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en2) v2_r <= s1_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage two: sample times channel multiplier.
  always_ff @(posedge clk) begin
    if (en2) begin
      prod_r  <= PROD_W'(s1_tag.sample * s1_coef.mult);
      bias2_r <= s1_coef.bias;
      sh2_r   <= s1_coef.shift;
      tag2_r  <= s1_tag;
    end
  end

  // Stage three: bias add, exact in 32 bits.
  assign acc_nxt = ACC_W'(prod_r) + ACC_W'(bias2_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      acc_r  <= acc_nxt;
      sh3_r  <= sh2_r;
      tag3_r <= tag2_r;
    end
  end

  // Stage four: round the magnitude half away from zero and shift.
  always_comb begin
    mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    rnd = (sh3_r == '0) ? '0 : ((ACC_W+1)'(1) << (sh3_r - SHIFT_W'(1)));
    sum = {1'b0, mag} + rnd;
    quo = sum >> sh3_r;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      q_r    <= quo[ACC_W-1:0];
      neg_r  <= acc_r[ACC_W-1];
      tag4_r <= tag3_r;
    end
  end

  // Stage five: restore the sign, clamp to the minimum, then the maximum.
  always_comb begin
    val         = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    lo_ext      = (ACC_W+1)'(bounds.lo);
    hi_ext      = (ACC_W+1)'(bounds.hi);
    low_clamped = (val < lo_ext) ? lo_ext : val;
    clamped     = (low_clamped > hi_ext) ? hi_ext : low_clamped;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      res_r  <= clamped[ACT_W-1:0];
      tag5_r <= tag4_r;
    end
  end

  assign out_valid          = v5_r;
  assign out_result         = res_r;
  assign out_result_channel = tag5_r.channel;
  assign out_plane_end      = tag5_r.plane_end;

  // The front end is held off only when every stage is full and blocked.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_ready |-> (s1_valid && v2_r && v3_r && v4_r && v5_r && out_stall))
    else $error("pipeline stalled with an empty stage");

  // An item in stage four reaches the output register once it is free.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && en5) |=> v5_r)
    else $error("item lost between stage four and the output");

endmodule
